// ===== hdl/bpa_pkg.sv =====
// Shared constants, types and codes of the buddy page allocator.
`default_nettype none
package bpa_pkg;

    localparam int FRAME_TOTAL = 1024;
    localparam int TOP_ORDER   = 6;
    localparam int PAGE_BYTES  = 4096;

    localparam int IDX_W      = $clog2(FRAME_TOTAL);
    localparam int LNK_W      = IDX_W + 1;
    localparam int ORD_W      = 3;
    localparam int HEADS      = 1 << ORD_W;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGES_W    = 33 - PAGE_SHIFT;
    localparam int BLK_FRAMES = 1 << TOP_ORDER;

    localparam logic [LNK_W-1:0] LINK_NULL = LNK_W'(FRAME_TOTAL);
    localparam logic [LNK_W-1:0] HEAD_INIT = LNK_W'(FRAME_TOTAL - BLK_FRAMES);

    typedef enum logic [1:0] {
        FS_PART  = 2'd0,
        FS_ALLOC = 2'd1,
        FS_FREE  = 2'd2
    } t_fstat;

    typedef enum logic [2:0] {
        RS_OK       = 3'd0,
        RS_SIZE     = 3'd1,
        RS_NOFREE   = 3'd2,
        RS_NOTALLOC = 3'd3,
        RS_RANGE    = 3'd4
    } t_rstat;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_FIND, S_A_UNLINK, S_A_SPLIT, S_A_SPLIT2,
        S_F_CHK, S_F_CHK2, S_F_PUSH2, S_M_RD, S_M_CHK, S_M_RDB,
        S_M_UNB, S_M_PUSH, S_M_PUSH2, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_A_FIND, OP_A_UNLINK, OP_A_SPLIT,
        OP_A_SPLIT2, OP_F_CHK, OP_F_CHK2, OP_F_PUSH2, OP_M_RD, OP_M_CHK,
        OP_M_RDB, OP_M_UNB, OP_M_PUSH, OP_M_PUSH2
    } t_op;

    typedef struct packed {
        logic clr_last;
        logic a_fail;
        logic at_want;
        logic range_err;
        logic not_alloc;
        logic at_top;
        logic merge_ok;
    } t_stat;

endpackage
`default_nettype wire

// ===== hdl/bpa_ctrl.sv =====
// Sequencer that steps the allocator datapath through each item.
`default_nettype none
module bpa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_operation,
    input  wire bpa_pkg::t_stat i_stat,
    output bpa_pkg::t_op       o_op,
    output logic               o_busy,
    output logic               o_done
);

    bpa_pkg::t_state r_state;
    bpa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpa_pkg::S_CLEAR: begin
                if (i_stat.clr_last) n_state = bpa_pkg::S_IDLE;
            end
            bpa_pkg::S_IDLE, bpa_pkg::S_DONE: begin
                if (i_start) begin
                    n_state = i_operation ? bpa_pkg::S_F_CHK : bpa_pkg::S_A_FIND;
                end else begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_A_FIND: begin
                n_state = i_stat.a_fail ? bpa_pkg::S_DONE : bpa_pkg::S_A_UNLINK;
            end
            bpa_pkg::S_A_UNLINK: n_state = bpa_pkg::S_A_SPLIT;
            bpa_pkg::S_A_SPLIT: begin
                n_state = i_stat.at_want ? bpa_pkg::S_DONE : bpa_pkg::S_A_SPLIT2;
            end
            bpa_pkg::S_A_SPLIT2: n_state = bpa_pkg::S_A_SPLIT;
            bpa_pkg::S_F_CHK: begin
                n_state = i_stat.range_err ? bpa_pkg::S_DONE : bpa_pkg::S_F_CHK2;
            end
            bpa_pkg::S_F_CHK2: begin
                n_state = i_stat.not_alloc ? bpa_pkg::S_DONE : bpa_pkg::S_F_PUSH2;
            end
            bpa_pkg::S_F_PUSH2: n_state = bpa_pkg::S_M_RD;
            bpa_pkg::S_M_RD: begin
                n_state = i_stat.at_top ? bpa_pkg::S_DONE : bpa_pkg::S_M_CHK;
            end
            bpa_pkg::S_M_CHK: begin
                n_state = i_stat.merge_ok ? bpa_pkg::S_M_RDB : bpa_pkg::S_DONE;
            end
            bpa_pkg::S_M_RDB:   n_state = bpa_pkg::S_M_UNB;
            bpa_pkg::S_M_UNB:   n_state = bpa_pkg::S_M_PUSH;
            bpa_pkg::S_M_PUSH:  n_state = bpa_pkg::S_M_PUSH2;
            bpa_pkg::S_M_PUSH2: n_state = bpa_pkg::S_M_RD;
            default:            n_state = bpa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_op   = bpa_pkg::OP_NONE;
        o_busy = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            bpa_pkg::S_CLEAR:    o_op = bpa_pkg::OP_CLEAR;
            bpa_pkg::S_IDLE: begin
                o_busy = 1'b0;
                o_op   = i_start ? bpa_pkg::OP_LOAD : bpa_pkg::OP_NONE;
            end
            bpa_pkg::S_DONE: begin
                o_busy = 1'b0;
                o_done = 1'b1;
                o_op   = i_start ? bpa_pkg::OP_LOAD : bpa_pkg::OP_NONE;
            end
            bpa_pkg::S_A_FIND:   o_op = bpa_pkg::OP_A_FIND;
            bpa_pkg::S_A_UNLINK: o_op = bpa_pkg::OP_A_UNLINK;
            bpa_pkg::S_A_SPLIT:  o_op = bpa_pkg::OP_A_SPLIT;
            bpa_pkg::S_A_SPLIT2: o_op = bpa_pkg::OP_A_SPLIT2;
            bpa_pkg::S_F_CHK:    o_op = bpa_pkg::OP_F_CHK;
            bpa_pkg::S_F_CHK2:   o_op = bpa_pkg::OP_F_CHK2;
            bpa_pkg::S_F_PUSH2:  o_op = bpa_pkg::OP_F_PUSH2;
            bpa_pkg::S_M_RD:     o_op = bpa_pkg::OP_M_RD;
            bpa_pkg::S_M_CHK:    o_op = bpa_pkg::OP_M_CHK;
            bpa_pkg::S_M_RDB:    o_op = bpa_pkg::OP_M_RDB;
            bpa_pkg::S_M_UNB:    o_op = bpa_pkg::OP_M_UNB;
            bpa_pkg::S_M_PUSH:   o_op = bpa_pkg::OP_M_PUSH;
            bpa_pkg::S_M_PUSH2:  o_op = bpa_pkg::OP_M_PUSH2;
            default:             o_op = bpa_pkg::OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/bpa_dpath.sv =====
// Frame tables, free-list heads and result registers of the allocator.
`default_nettype none
module bpa_dpath (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire bpa_pkg::t_op            i_op,
    input  wire logic [31:0]             i_size_bytes,
    input  wire logic [31:0]             i_address,
    input  wire logic                    i_cfg_valid,
    input  wire logic [31:0]             i_cfg_data,
    output bpa_pkg::t_stat               o_stat,
    output logic [31:0]                  o_block_address,
    output logic [2:0]                   o_order_given,
    output logic [2:0]                   o_status
);

    localparam int IW = bpa_pkg::IDX_W;
    localparam int LW = bpa_pkg::LNK_W;
    localparam int OW = bpa_pkg::ORD_W;

    logic [OW-1:0]    r_ord_mem [bpa_pkg::FRAME_TOTAL];
    bpa_pkg::t_fstat  r_sta_mem [bpa_pkg::FRAME_TOTAL];
    logic [LW-1:0]    r_nxt_mem [bpa_pkg::FRAME_TOTAL];
    logic [LW-1:0]    r_prv_mem [bpa_pkg::FRAME_TOTAL];

    logic [LW-1:0]    r_head [bpa_pkg::HEADS];
    logic [31:0]      r_base;
    logic [31:0]      r_size;
    logic [31:0]      r_addr;
    logic [IW-1:0]    r_f;
    logic [IW-1:0]    r_b;
    logic [OW-1:0]    r_o;
    logic [OW-1:0]    r_want;
    logic [LW-1:0]    r_h;
    logic [IW-1:0]    r_clr;
    logic [OW-1:0]    r_rd_ord;
    bpa_pkg::t_fstat  r_rd_sta;
    logic [LW-1:0]    r_rd_nxt;
    logic [LW-1:0]    r_rd_prv;
    logic [31:0]      r_res_addr;
    logic [OW-1:0]    r_res_order;
    bpa_pkg::t_rstat  r_res_status;

    logic [32:0]              size_sum;
    logic [bpa_pkg::PAGES_W-1:0] pages;
    logic [bpa_pkg::PAGES_W-1:0] pages_m1;
    logic                     size_err;
    logic [OW-1:0]            want;
    logic                     found;
    logic [OW-1:0]            found_o;
    logic [31:0]              diff;
    logic                     range_err;
    logic [IW-1:0]            frame;
    logic [OW-1:0]            oc;
    logic [OW-1:0]            o1;
    logic [IW-1:0]            b_split;
    logic [IW-1:0]            b_buddy;
    logic [IW-1:0]            lo;
    logic [IW-1:0]            hi;
    logic [IW-1:0]            rd_addr;
    logic                     clr_head;
    logic [LW-1:0]            clr_nxt;
    logic [LW-1:0]            clr_prv;
    logic [LW-1:0]            clr_up;

    logic                     ord_we;
    logic [IW-1:0]            ord_wa;
    logic [OW-1:0]            ord_wd;
    logic                     sta_we;
    logic [IW-1:0]            sta_wa;
    bpa_pkg::t_fstat          sta_wd;
    logic                     nxt_we;
    logic [IW-1:0]            nxt_wa;
    logic [LW-1:0]            nxt_wd;
    logic                     prv_we;
    logic [IW-1:0]            prv_wa;
    logic [LW-1:0]            prv_wd;

    always_comb begin
        size_sum = {1'b0, r_size} + 33'(bpa_pkg::PAGE_BYTES - 1);
        pages    = size_sum[32:bpa_pkg::PAGE_SHIFT];
        pages_m1 = pages - bpa_pkg::PAGES_W'(1);
        size_err = (pages == '0) || ((pages_m1 >> bpa_pkg::TOP_ORDER) != '0);
        want     = '0;
        for (int i = 0; i < bpa_pkg::TOP_ORDER; i++) begin
            if (pages_m1[i]) want = OW'(i + 1);
        end
        found   = 1'b0;
        found_o = '0;
        for (int o = bpa_pkg::TOP_ORDER; o >= 0; o--) begin
            if (OW'(o) >= want && r_head[o] != bpa_pkg::LINK_NULL) begin
                found   = 1'b1;
                found_o = OW'(o);
            end
        end
    end

    always_comb begin
        diff      = r_addr - r_base;
        range_err = (32'(diff >> bpa_pkg::PAGE_SHIFT) >= 32'(bpa_pkg::FRAME_TOTAL));
        frame     = diff[bpa_pkg::PAGE_SHIFT +: IW];
        oc        = r_o - OW'(1);
        o1        = r_o + OW'(1);
        b_split   = r_f + (IW'(1) << oc);
        b_buddy   = r_f ^ (IW'(1) << r_o);
        lo        = (r_f < r_b) ? r_f : r_b;
        hi        = (r_f < r_b) ? r_b : r_f;
        clr_head  = (r_clr[bpa_pkg::TOP_ORDER-1:0] == '0);
        clr_up    = {1'b0, r_clr} + LW'(bpa_pkg::BLK_FRAMES);
        clr_nxt   = bpa_pkg::LINK_NULL;
        clr_prv   = bpa_pkg::LINK_NULL;
        if (clr_head && r_clr >= IW'(bpa_pkg::BLK_FRAMES)) begin
            clr_nxt = {1'b0, r_clr} - LW'(bpa_pkg::BLK_FRAMES);
        end
        if (clr_head && clr_up < LW'(bpa_pkg::FRAME_TOTAL)) begin
            clr_prv = clr_up;
        end
    end

    always_comb begin
        unique case (i_op)
            bpa_pkg::OP_A_FIND: rd_addr = r_head[found_o][IW-1:0];
            bpa_pkg::OP_F_CHK:  rd_addr = frame;
            bpa_pkg::OP_M_RD:   rd_addr = b_buddy;
            bpa_pkg::OP_M_RDB:  rd_addr = r_b;
            default:            rd_addr = r_f;
        endcase
    end

    always_comb begin
        ord_we = 1'b0;
        ord_wa = r_f;
        ord_wd = r_o;
        sta_we = 1'b0;
        sta_wa = r_f;
        sta_wd = bpa_pkg::FS_PART;
        nxt_we = 1'b0;
        nxt_wa = r_f;
        nxt_wd = bpa_pkg::LINK_NULL;
        prv_we = 1'b0;
        prv_wa = r_f;
        prv_wd = bpa_pkg::LINK_NULL;
        unique case (i_op)
            bpa_pkg::OP_CLEAR: begin
                ord_we = 1'b1;
                ord_wa = r_clr;
                ord_wd = clr_head ? OW'(bpa_pkg::TOP_ORDER) : '0;
                sta_we = 1'b1;
                sta_wa = r_clr;
                sta_wd = clr_head ? bpa_pkg::FS_FREE : bpa_pkg::FS_PART;
                nxt_we = 1'b1;
                nxt_wa = r_clr;
                nxt_wd = clr_nxt;
                prv_we = 1'b1;
                prv_wa = r_clr;
                prv_wd = clr_prv;
            end
            bpa_pkg::OP_A_UNLINK: begin
                sta_we = 1'b1;
                sta_wd = bpa_pkg::FS_ALLOC;
                nxt_we = 1'b1;
                prv_we = (r_rd_nxt != bpa_pkg::LINK_NULL);
                prv_wa = r_rd_nxt[IW-1:0];
            end
            bpa_pkg::OP_A_SPLIT: begin
                if (r_o == r_want) begin
                    ord_we = 1'b1;
                    ord_wd = r_want;
                end else begin
                    ord_we = 1'b1;
                    ord_wa = b_split;
                    ord_wd = oc;
                    sta_we = 1'b1;
                    sta_wa = b_split;
                    sta_wd = bpa_pkg::FS_FREE;
                    nxt_we = 1'b1;
                    nxt_wa = b_split;
                    nxt_wd = r_head[oc];
                    prv_we = 1'b1;
                    prv_wa = b_split;
                end
            end
            bpa_pkg::OP_A_SPLIT2: begin
                prv_we = (r_h != bpa_pkg::LINK_NULL);
                prv_wa = r_h[IW-1:0];
                prv_wd = {1'b0, r_b};
            end
            bpa_pkg::OP_F_CHK2: begin
                if (r_rd_sta == bpa_pkg::FS_ALLOC) begin
                    sta_we = 1'b1;
                    sta_wd = bpa_pkg::FS_FREE;
                    nxt_we = 1'b1;
                    nxt_wd = r_head[r_rd_ord];
                    prv_we = 1'b1;
                end
            end
            bpa_pkg::OP_F_PUSH2, bpa_pkg::OP_M_PUSH2: begin
                prv_we = (r_h != bpa_pkg::LINK_NULL);
                prv_wa = r_h[IW-1:0];
                prv_wd = {1'b0, r_f};
                sta_we = (i_op == bpa_pkg::OP_M_PUSH2);
                sta_wa = r_b;
                sta_wd = bpa_pkg::FS_PART;
            end
            bpa_pkg::OP_M_CHK: begin
                if (o_stat.merge_ok && r_h != bpa_pkg::LINK_NULL) begin
                    prv_we = 1'b1;
                    prv_wa = r_h[IW-1:0];
                end
            end
            bpa_pkg::OP_M_UNB: begin
                nxt_we = (r_rd_prv != bpa_pkg::LINK_NULL);
                nxt_wa = r_rd_prv[IW-1:0];
                nxt_wd = r_rd_nxt;
                prv_we = (r_rd_nxt != bpa_pkg::LINK_NULL);
                prv_wa = r_rd_nxt[IW-1:0];
                prv_wd = r_rd_prv;
            end
            bpa_pkg::OP_M_PUSH: begin
                ord_we = 1'b1;
                ord_wa = lo;
                ord_wd = o1;
                sta_we = 1'b1;
                sta_wa = lo;
                sta_wd = bpa_pkg::FS_FREE;
                nxt_we = 1'b1;
                nxt_wa = lo;
                nxt_wd = r_head[o1];
                prv_we = 1'b1;
                prv_wa = lo;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) r_ord_mem[ord_wa] <= ord_wd;
        if (sta_we) r_sta_mem[sta_wa] <= sta_wd;
        if (nxt_we) r_nxt_mem[nxt_wa] <= nxt_wd;
        if (prv_we) r_prv_mem[prv_wa] <= prv_wd;
        r_rd_ord <= r_ord_mem[rd_addr];
        r_rd_sta <= r_sta_mem[rd_addr];
        r_rd_nxt <= r_nxt_mem[rd_addr];
        r_rd_prv <= r_prv_mem[rd_addr];
    end

    always_comb begin
        o_stat.clr_last  = (r_clr == IW'(bpa_pkg::FRAME_TOTAL - 1));
        o_stat.a_fail    = size_err || !found;
        o_stat.at_want   = (r_o == r_want);
        o_stat.range_err = range_err;
        o_stat.not_alloc = (r_rd_sta != bpa_pkg::FS_ALLOC);
        o_stat.at_top    = (r_o == OW'(bpa_pkg::TOP_ORDER));
        o_stat.merge_ok  = (r_rd_sta == bpa_pkg::FS_FREE) && (r_rd_ord == r_o);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_clr  <= '0;
            for (int o = 0; o < bpa_pkg::HEADS; o++) begin
                r_head[o] <= (o == bpa_pkg::TOP_ORDER) ? bpa_pkg::HEAD_INIT
                                                       : bpa_pkg::LINK_NULL;
            end
        end else begin
            if (i_cfg_valid) r_base <= i_cfg_data;
            unique case (i_op)
                bpa_pkg::OP_CLEAR: begin
                    r_clr <= r_clr + IW'(1);
                end
                bpa_pkg::OP_A_UNLINK: begin
                    r_head[r_o] <= r_rd_nxt;
                end
                bpa_pkg::OP_A_SPLIT: begin
                    if (r_o != r_want) r_head[oc] <= {1'b0, b_split};
                end
                bpa_pkg::OP_F_CHK2: begin
                    if (r_rd_sta == bpa_pkg::FS_ALLOC) r_head[r_rd_ord] <= {1'b0, r_f};
                end
                bpa_pkg::OP_M_CHK: begin
                    if (o_stat.merge_ok) r_head[r_o] <= r_h;
                end
                bpa_pkg::OP_M_UNB: begin
                    if (r_head[r_o] == {1'b0, r_b}) r_head[r_o] <= r_rd_nxt;
                end
                bpa_pkg::OP_M_PUSH: begin
                    r_head[o1] <= {1'b0, lo};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            bpa_pkg::OP_LOAD: begin
                r_size <= i_size_bytes;
                r_addr <= i_address;
            end
            bpa_pkg::OP_A_FIND: begin
                r_want <= want;
                r_o    <= found_o;
                r_f    <= r_head[found_o][IW-1:0];
                if (size_err) begin
                    r_res_addr   <= '0;
                    r_res_order  <= '0;
                    r_res_status <= bpa_pkg::RS_SIZE;
                end else if (!found) begin
                    r_res_addr   <= '0;
                    r_res_order  <= '0;
                    r_res_status <= bpa_pkg::RS_NOFREE;
                end
            end
            bpa_pkg::OP_A_SPLIT: begin
                if (r_o == r_want) begin
                    r_res_addr   <= r_base + (32'(r_f) << bpa_pkg::PAGE_SHIFT);
                    r_res_order  <= r_want;
                    r_res_status <= bpa_pkg::RS_OK;
                end else begin
                    r_h <= r_head[oc];
                    r_b <= b_split;
                    r_o <= oc;
                end
            end
            bpa_pkg::OP_F_CHK: begin
                r_f <= frame;
                if (range_err) begin
                    r_res_addr   <= '0;
                    r_res_order  <= '0;
                    r_res_status <= bpa_pkg::RS_RANGE;
                end
            end
            bpa_pkg::OP_F_CHK2: begin
                r_o <= r_rd_ord;
                r_h <= r_head[r_rd_ord];
                if (r_rd_sta != bpa_pkg::FS_ALLOC) begin
                    r_res_addr   <= '0;
                    r_res_order  <= '0;
                    r_res_status <= bpa_pkg::RS_NOTALLOC;
                end
            end
            bpa_pkg::OP_M_RD: begin
                r_b <= b_buddy;
                r_res_addr   <= '0;
                r_res_order  <= r_o;
                r_res_status <= bpa_pkg::RS_OK;
            end
            bpa_pkg::OP_M_PUSH: begin
                r_h <= r_head[o1];
                r_f <= lo;
                r_b <= hi;
                r_o <= o1;
            end
            default: begin
            end
        endcase
    end

    assign o_block_address = r_res_addr;
    assign o_order_given   = r_res_order;
    assign o_status        = r_res_status;

endmodule
`default_nettype wire

// ===== hdl/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: sequencer plus datapath.
`default_nettype none
// An item is taken when start is high and busy is low. operation 0 allocates
// a block of at least size_bytes bytes; operation 1 frees the block at address.
// Every item gives exactly one result: o_done is high for one cycle with
// o_block_address, o_order_given and o_status valid, and the receiver must
// take it then. Allocation runs find and unlink, then a split and a link
// fix-up per split (0 to 6 splits). A free runs range check, state check, push
// and buddy read, then, below the top order, a merge check and per merge an
// unlink, push and buddy read (0 to 6 merges). The frame tables, each with one
// read and one write port, are read and then written once per step of the
// list walks. A new item can be started in the cycle that shows a result.
// After reset the frame tables are swept one frame per cycle over all 1024
// frames with busy high; all memory then sits in free blocks of the top order.
// memory_base is to be written through i_cfg_valid and i_cfg_data while idle;
// the block itself does not enforce it. o_cfg_ready is always high.
module buddy_page_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_size_bytes,
    input  wire logic [31:0] i_address,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_done,
    output logic [31:0]      o_block_address,
    output logic [2:0]       o_order_given,
    output logic [2:0]       o_status
);

    bpa_pkg::t_op   op;
    bpa_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_op        (op),
        .o_busy      (busy),
        .o_done      (o_done)
    );

    bpa_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .i_size_bytes    (i_size_bytes),
        .i_address       (i_address),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_stat          (stat),
        .o_block_address (o_block_address),
        .o_order_given   (o_order_given),
        .o_status        (o_status)
    );

endmodule
`default_nettype wire
